// ===== design/scfs_pkg.sv =====
// ----------------------------------------------------------------------------
// scfs_pkg: shared types and constants for the SDRAM set-up sequencer
// Holds the run parameters decoded from the SPD data, the result record,
// the access kinds and the fixed register offsets and values.
// ----------------------------------------------------------------------------
`default_nettype none

package scfs_pkg;

  localparam int unsigned IN_W   = 88;
  localparam int unsigned OUT_W  = 56;
  localparam int unsigned USER_W = 3;
  localparam int unsigned STEP_W = 6;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_WORD = 2'd1,
    KIND_MEM  = 2'd2
  } kind_t;

  // Register offsets
  localparam logic [7:0] OFF_53    = 8'h53;
  localparam logic [7:0] OFF_68    = 8'h68;
  localparam logic [7:0] OFF_MBSC0 = 8'h69;
  localparam logic [7:0] OFF_MBSC1 = 8'h6a;
  localparam logic [7:0] OFF_MBSC3 = 8'h6c;
  localparam logic [7:0] OFF_MBFS0 = 8'hca;
  localparam logic [7:0] OFF_MBFS2 = 8'hcc;
  localparam logic [7:0] OFF_DRB0  = 8'h60;
  localparam logic [7:0] OFF_RPS   = 8'h74;
  localparam logic [7:0] OFF_PGPOL = 8'h78;
  localparam logic [7:0] OFF_DRAMC = 8'h57;
  localparam logic [7:0] OFF_DRAMT = 8'h58;
  localparam logic [7:0] OFF_SDRAMC = 8'h76;
  localparam logic [7:0] OFF_PMCR  = 8'h7a;

  // Fixed values
  localparam logic [15:0] MODE_HI_CL2 = 16'h1ea8;
  localparam logic [15:0] MODE_HI_CL3 = 16'h1e28;
  localparam logic [15:0] MODE_LO_CL2 = 16'h0150;
  localparam logic [15:0] MODE_LO_CL3 = 16'h01d0;
  localparam logic [15:0] MBSC1_BASE  = 16'hafea;
  localparam logic [15:0] MBSC3_BASE  = 16'hb00a;
  localparam logic [15:0] NORM_BASE   = 16'h0103;
  localparam logic [15:0] MBSC1_ADD   = 16'h003c;
  localparam logic [15:0] MBSC3_ADD   = 16'hc000;
  localparam logic [15:0] PGPOL_BASE  = 16'h0008;
  localparam logic [7:0]  MBFS2_BASE  = 8'h1e;
  localparam logic [7:0]  MBSC0_BASE  = 8'haa;
  localparam logic [7:0]  VAL_53      = 8'hff;
  localparam logic [7:0]  VAL_DRAMT   = 8'h03;

  // SDRAMC command codes
  localparam logic [15:0] CMD_NOP  = 16'h0020;
  localparam logic [15:0] CMD_PRE  = 16'h0040;
  localparam logic [15:0] CMD_CBR  = 16'h0080;
  localparam logic [15:0] CMD_MODE = 16'h0060;
  localparam logic [15:0] CL2_BIT  = 16'h0004;

  // Sequence positions
  localparam logic [STEP_W-1:0] ST_53       = 6'd0;
  localparam logic [STEP_W-1:0] ST_68       = 6'd1;
  localparam logic [STEP_W-1:0] ST_MBSC0    = 6'd2;
  localparam logic [STEP_W-1:0] ST_MBSC1    = 6'd3;
  localparam logic [STEP_W-1:0] ST_MBSC3    = 6'd4;
  localparam logic [STEP_W-1:0] ST_MBFS0    = 6'd5;
  localparam logic [STEP_W-1:0] ST_MBFS2    = 6'd6;
  localparam logic [STEP_W-1:0] ST_DRB0     = 6'd7;
  localparam logic [STEP_W-1:0] ST_DRB7     = 6'd14;
  localparam logic [STEP_W-1:0] ST_RPS      = 6'd15;
  localparam logic [STEP_W-1:0] ST_PGPOL    = 6'd16;
  localparam logic [STEP_W-1:0] ST_DRAMC    = 6'd17;
  localparam logic [STEP_W-1:0] ST_DRAMT    = 6'd18;
  localparam logic [STEP_W-1:0] ST_NOP      = 6'd19;
  localparam logic [STEP_W-1:0] ST_NOP_MEM  = 6'd20;
  localparam logic [STEP_W-1:0] ST_PRE      = 6'd21;
  localparam logic [STEP_W-1:0] ST_PRE_MEM  = 6'd22;
  localparam logic [STEP_W-1:0] ST_CBR_LO   = 6'd23;
  localparam logic [STEP_W-1:0] ST_CBR_HI   = 6'd38;
  localparam logic [STEP_W-1:0] ST_MODE     = 6'd39;
  localparam logic [STEP_W-1:0] ST_MODE_MEM = 6'd40;
  localparam logic [STEP_W-1:0] ST_NORM     = 6'd41;
  localparam logic [STEP_W-1:0] ST_DRAMC_F  = 6'd42;
  localparam logic [STEP_W-1:0] ST_PMCR     = 6'd43;

  // Parameters of one run, decoded when the item is taken
  typedef struct packed {
    logic        ok;
    logic [2:0]  first;
    logic [2:0]  last_row;   // one past the last populated row
    logic [1:0]  rows;
    logic        cl2;
    logic [1:0]  page;
    logic [2:0]  drb_sh;     // log2 of DRB units per row
    logic [30:0] total;
    logic        dramc_b5;
    logic [7:0]  pmcr;
  } run_t;

  typedef struct packed {
    logic        status;
    kind_t       kind;
    logic [7:0]  offset;
    logic [15:0] value;
    logic [30:0] total;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== design/sdram_config_from_spd_unit.sv =====
// ----------------------------------------------------------------------------
// sdram_config_from_spd_unit: SDRAM controller set-up from SPD data
// Checks one module's SPD fields and plays out the host bridge programming
// sequence as a stream of configuration writes and dummy memory accesses.
// ----------------------------------------------------------------------------
// The item is first registered into the run parameters and step counter; each
//   result is then registered into the output register once that is free.
// Throughput: a supported module gives 44 results, one per cycle while the
//   output is not held by m_tready; an unsupported one gives a single error
//   result. The step counter walks the sequence.
// The next item is taken in the cycle the last result of a run loads.
// Reset (rst, synchronous) empties the output register and idles the counter.
// ----------------------------------------------------------------------------
`default_nettype none

module sdram_config_from_spd_unit (
  input  logic                         clk,
  input  logic                         rst,
  // s_tdata, low bit up: mem_type[7:0], row_addr_bits[15:8],
  // col_addr_bits[23:16], module_rows[31:24], bus_width[47:32],
  // chip_banks[55:48], cas_support[63:56], slot_address[70:64],
  // dramc_current[78:71], pmcr_current[86:79], zero pad [87]
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [scfs_pkg::IN_W-1:0]    s_tdata,
  // m_tdata, low bit up: reg_offset[7:0], write_value[23:8],
  // installed_size[54:24], zero pad [55]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [scfs_pkg::OUT_W-1:0]   m_tdata,
  // m_tuser, low bit up: status[0], access_kind[2:1]
  output logic [scfs_pkg::USER_W-1:0]  m_tuser,
  output logic                         m_tlast
);
  import scfs_pkg::*;

  // Input fields
  logic [7:0]  mem_type;
  logic [7:0]  row_addr_bits;
  logic [7:0]  col_addr_bits;
  logic [7:0]  module_rows;
  logic [15:0] bus_width;
  logic [7:0]  chip_banks;
  logic [7:0]  cas_support;
  logic [6:0]  slot_address;
  logic [7:0]  dramc_current;
  logic [7:0]  pmcr_current;

  assign mem_type      = s_tdata[7:0];
  assign row_addr_bits = s_tdata[15:8];
  assign col_addr_bits = s_tdata[23:16];
  assign module_rows   = s_tdata[31:24];
  assign bus_width     = s_tdata[47:32];
  assign chip_banks    = s_tdata[55:48];
  assign cas_support   = s_tdata[63:56];
  assign slot_address  = s_tdata[70:64];
  assign dramc_current = s_tdata[78:71];
  assign pmcr_current  = s_tdata[86:79];

  // Decode of the incoming item
  run_t       run_next;
  logic       bad_spd;
  logic [4:0] sum_bits;

  always_comb begin
    bad_spd = (mem_type != 8'd4) || (bus_width != 16'd64) ||
              (module_rows == 8'd0) || (module_rows > 8'd2) ||
              (row_addr_bits < 8'd11) || (row_addr_bits > 8'd13) ||
              (col_addr_bits < 8'd8) || (col_addr_bits > 8'd10) ||
              (chip_banks != 8'd4) ||
              (slot_address < 7'h50) || (slot_address > 7'h52);
    run_next.first    = {slot_address[1:0], 1'b0};
    run_next.rows     = module_rows[1:0];
    run_next.last_row = run_next.first + {1'b0, module_rows[1:0]};
    // CL3 wins when both are offered; no usable latency rejects the module
    run_next.cl2      = !cas_support[2];
    run_next.page     = col_addr_bits[1:0];
    run_next.ok       = !bad_spd && (run_next.last_row <= 3'd6) &&
                        (cas_support[2] || cas_support[1]);
    // Row size is 2^(row + col + 5) bytes; one DRB unit is 8 MiB
    sum_bits          = 5'(row_addr_bits[3:0]) + 5'(col_addr_bits[3:0]);
    run_next.drb_sh   = 3'(sum_bits - 5'd18);
    run_next.total    = 31'd1 << (sum_bits + 5'd5 + 5'(module_rows[1]));
    run_next.dramc_b5 = dramc_current[5];
    run_next.pmcr     = pmcr_current;
  end

  // Run state
  run_t                run;
  logic                busy;
  logic [STEP_W-1:0]   step;
  res_t                res;
  logic                adv;
  logic                fin;
  logic                take;

  scfs_seq u_seq (
    .run  (run),
    .step (step),
    .res  (res)
  );

  // Advance while busy whenever the output register is free or being emptied
  assign adv      = busy && (!m_tvalid || m_tready);
  assign fin      = !run.ok || (step == ST_PMCR);
  assign s_tready = !busy || (adv && fin);
  assign take     = s_tvalid && s_tready;

  res_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (take) begin
        busy <= 1'b1;
        step <= '0;
      end else if (adv) begin
        step <= step + STEP_W'(1);
        if (fin) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Payload registers: hold the run parameters and the result in flight
  always_ff @(posedge clk) begin
    if (take) begin
      run <= run_next;
    end
    if (adv) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0, out_res.total, out_res.value, out_res.offset};
  assign m_tuser = {out_res.kind, out_res.status};
  assign m_tlast = out_res.last;

endmodule

`default_nettype wire

// ===== design/scfs_seq.sv =====
// ----------------------------------------------------------------------------
// scfs_seq: result generator
// Maps the run parameters and the sequence position to one result record.
// ----------------------------------------------------------------------------
`default_nettype none

module scfs_seq (
  input  scfs_pkg::run_t                  run,
  input  logic [scfs_pkg::STEP_W-1:0]     step,
  output scfs_pkg::res_t                  res
);
  import scfs_pkg::*;

  logic        mid_hit;
  logic        hi_rows;
  logic [15:0] norm;
  logic [15:0] mode;
  logic [15:0] rps;
  logic [15:0] pgpol;
  logic [2:0]  r;
  logic [1:0]  cnt;
  logic [7:0]  drb_acc;
  logic [7:0]  d57;

  always_comb begin
    mid_hit = (run.first < 3'd4) && (run.last_row > 3'd2);
    hi_rows = run.last_row > 3'd4;
    norm    = NORM_BASE | (run.cl2 ? CL2_BIT : 16'h0000);
    if (run.first >= 3'd4) begin
      mode = run.cl2 ? MODE_HI_CL2 : MODE_HI_CL3;
    end else begin
      mode = run.cl2 ? MODE_LO_CL2 : MODE_LO_CL3;
    end
    d57 = {2'b00, run.dramc_b5, 5'b01000};

    rps   = '0;
    pgpol = PGPOL_BASE;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) >= run.first && 3'(i) < run.last_row) begin
        rps[2*i +: 2] = run.page;
        pgpol[8+i]    = 1'b1;
      end
    end

    // Cumulative DRB: rows populated up to and including this one
    r = 3'(step - ST_DRB0);
    if (r < run.first) begin
      cnt = 2'd0;
    end else if (r < run.last_row) begin
      cnt = 2'(r - run.first + 3'd1);
    end else begin
      cnt = run.rows;
    end
    drb_acc = 8'(cnt) << run.drb_sh;
  end

  always_comb begin
    res        = '0;
    res.total  = run.total;
    res.kind   = KIND_BYTE;
    case (step) inside
      ST_53:     begin res.offset = OFF_53;    res.value = 16'(VAL_53); end
      ST_68:     begin res.offset = OFF_68; end
      ST_MBSC0:  begin
        res.offset = OFF_MBSC0;
        res.value  = 16'(MBSC0_BASE | (hi_rows ? 8'h30 : 8'h00));
      end
      ST_MBSC1:  begin
        res.kind   = KIND_WORD;
        res.offset = OFF_MBSC1;
        res.value  = MBSC1_BASE | (mid_hit ? MBSC1_ADD : 16'h0000);
      end
      ST_MBSC3:  begin
        res.kind   = KIND_WORD;
        res.offset = OFF_MBSC3;
        res.value  = MBSC3_BASE | (mid_hit ? 16'h0000 : MBSC3_ADD);
      end
      ST_MBFS0:  begin
        res.kind   = KIND_WORD;
        res.offset = OFF_MBFS0;
        res.value  = hi_rows ? 16'h0002 : 16'h0000;
      end
      ST_MBFS2:  begin
        res.offset = OFF_MBFS2;
        res.value  = 16'(MBFS2_BASE | (mid_hit ? 8'h40 : 8'h00));
      end
      [ST_DRB0:ST_DRB7]: begin
        res.offset = OFF_DRB0 + 8'(r);
        res.value  = 16'(drb_acc);
      end
      ST_RPS:    begin res.kind = KIND_WORD; res.offset = OFF_RPS;   res.value = rps; end
      ST_PGPOL:  begin res.kind = KIND_WORD; res.offset = OFF_PGPOL; res.value = pgpol; end
      ST_DRAMC:  begin res.offset = OFF_DRAMC; res.value = 16'(d57); end
      ST_DRAMT:  begin res.offset = OFF_DRAMT; res.value = 16'(VAL_DRAMT); end
      ST_NOP:    begin
        res.kind = KIND_WORD; res.offset = OFF_SDRAMC; res.value = norm | CMD_NOP;
      end
      ST_PRE:    begin
        res.kind = KIND_WORD; res.offset = OFF_SDRAMC; res.value = norm | CMD_PRE;
      end
      ST_NOP_MEM, ST_PRE_MEM: begin
        res.kind = KIND_MEM;
      end
      [ST_CBR_LO:ST_CBR_HI]: begin
        // Odd positions carry the CBR command, even ones its dummy access
        if (step[0]) begin
          res.kind = KIND_WORD; res.offset = OFF_SDRAMC; res.value = norm | CMD_CBR;
        end else begin
          res.kind = KIND_MEM;
        end
      end
      ST_MODE:   begin
        res.kind = KIND_WORD; res.offset = OFF_SDRAMC; res.value = norm | CMD_MODE;
      end
      ST_MODE_MEM: begin res.kind = KIND_MEM; res.value = mode; end
      ST_NORM:   begin res.kind = KIND_WORD; res.offset = OFF_SDRAMC; res.value = norm; end
      ST_DRAMC_F: begin
        res.offset = OFF_DRAMC;
        res.value  = 16'((d57 & 8'h20) | 8'h09);
      end
      ST_PMCR:   begin
        res.offset = OFF_PMCR;
        res.value  = 16'(run.pmcr | 8'h10);
        res.last   = 1'b1;
      end
      default:   res = '0;
    endcase
    // Unsupported module: one error result, everything else cleared
    if (!run.ok) begin
      res        = '0;
      res.status = 1'b1;
      res.last   = 1'b1;
    end
  end

endmodule

`default_nettype wire
